### src/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared widths and beat types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package lsi_pkg;

   localparam int COORD_BITS = 32;
   localparam int DIFF_BITS  = COORD_BITS + 1;   // coordinate difference
   localparam int PROD_BITS  = 2 * DIFF_BITS;    // product of two differences
   localparam int NUM_BITS   = PROD_BITS + 1;    // cross product / numerators
   localparam int REM_BITS   = PROD_BITS + 1;    // partial remainder before reduce

   typedef struct packed {
      logic signed [COORD_BITS-1:0] wall_start_x;
      logic signed [COORD_BITS-1:0] wall_start_y;
      logic signed [COORD_BITS-1:0] wall_end_x;
      logic signed [COORD_BITS-1:0] wall_end_y;
      logic signed [COORD_BITS-1:0] ray_from_x;
      logic signed [COORD_BITS-1:0] ray_from_y;
      logic signed [COORD_BITS-1:0] ray_to_x;
      logic signed [COORD_BITS-1:0] ray_to_y;
   } lsi_req_type;

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] hit_x;
      logic signed [COORD_BITS-1:0] hit_y;
   } lsi_rsp_type;

   // One axis of the scaled division tn * |d| / cp.
   typedef struct packed {
      logic [PROD_BITS-1:0]  r;     // partial remainder, below cp
      logic [DIFF_BITS-1:0]  q;     // partial quotient
      logic [DIFF_BITS-1:0]  m;     // |d|, consumed from the top
      logic                  neg;   // sign of d
      logic [COORD_BITS-1:0] p;     // probe start coordinate
   } lsi_lane_type;

   typedef struct packed {
      logic                 hit;
      logic [PROD_BITS-1:0] tn;
      logic [PROD_BITS-1:0] cp;
      lsi_lane_type         x;
      lsi_lane_type         y;
   } lsi_cell_type;

endpackage

### src/lsi_front.sv
// ----------------------------------------------------------------------------
// lsi_front
// Differences, products, cross product, sign fix and range test.
// ----------------------------------------------------------------------------
module lsi_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lsi_pkg::lsi_req_type req_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lsi_pkg::lsi_cell_type out_data
);
   import lsi_pkg::*;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] dx, dy, lx, ly, ax, ay;
      logic [COORD_BITS-1:0]       px, py;
   } stage_a_type;

   typedef struct packed {
      logic signed [PROD_BITS-1:0] m0, m1, m2, m3, m4, m5;
      logic signed [DIFF_BITS-1:0] dx, dy;
      logic [COORD_BITS-1:0]       px, py;
   } stage_b_type;

   typedef struct packed {
      logic signed [NUM_BITS-1:0]  cp, sn, tn;
      logic signed [DIFF_BITS-1:0] dx, dy;
      logic [COORD_BITS-1:0]       px, py;
   } stage_c_type;

   typedef struct packed {
      logic                        nz;
      logic signed [NUM_BITS-1:0]  cp, sn, tn;
      logic [DIFF_BITS-1:0]        mx, my;
      logic                        nx, ny;
      logic [COORD_BITS-1:0]       px, py;
   } stage_d_type;

   stage_a_type  a_ff, a_in;
   stage_b_type  b_ff, b_in;
   stage_c_type  c_ff, c_in;
   stage_d_type  d_ff, d_in;
   lsi_cell_type e_ff, e_in;
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

   assign rdy_e     = !ve_ff || out_ready;
   assign rdy_d     = !vd_ff || rdy_e;
   assign rdy_c     = !vc_ff || rdy_d;
   assign rdy_b     = !vb_ff || rdy_c;
   assign rdy_a     = !va_ff || rdy_b;
   assign req_ready = rdy_a;
   assign out_valid = ve_ff;
   assign out_data  = e_ff;

   always_comb begin
      a_in.dx = DIFF_BITS'(req_data.ray_to_x) - DIFF_BITS'(req_data.ray_from_x);
      a_in.dy = DIFF_BITS'(req_data.ray_to_y) - DIFF_BITS'(req_data.ray_from_y);
      a_in.lx = DIFF_BITS'(req_data.wall_end_x) - DIFF_BITS'(req_data.wall_start_x);
      a_in.ly = DIFF_BITS'(req_data.wall_end_y) - DIFF_BITS'(req_data.wall_start_y);
      a_in.ax = DIFF_BITS'(req_data.ray_from_x) - DIFF_BITS'(req_data.wall_start_x);
      a_in.ay = DIFF_BITS'(req_data.ray_from_y) - DIFF_BITS'(req_data.wall_start_y);
      a_in.px = req_data.ray_from_x;
      a_in.py = req_data.ray_from_y;
   end

   always_comb begin
      b_in.m0 = a_ff.dx * a_ff.ly;
      b_in.m1 = a_ff.lx * a_ff.dy;
      b_in.m2 = a_ff.dx * a_ff.ay;
      b_in.m3 = a_ff.dy * a_ff.ax;
      b_in.m4 = a_ff.lx * a_ff.ay;
      b_in.m5 = a_ff.ly * a_ff.ax;
      b_in.dx = a_ff.dx;
      b_in.dy = a_ff.dy;
      b_in.px = a_ff.px;
      b_in.py = a_ff.py;
   end

   always_comb begin
      c_in.cp = NUM_BITS'(b_ff.m0) - NUM_BITS'(b_ff.m1);
      c_in.sn = NUM_BITS'(b_ff.m2) - NUM_BITS'(b_ff.m3);
      c_in.tn = NUM_BITS'(b_ff.m4) - NUM_BITS'(b_ff.m5);
      c_in.dx = b_ff.dx;
      c_in.dy = b_ff.dy;
      c_in.px = b_ff.px;
      c_in.py = b_ff.py;
   end

   // Make cp positive so the range test is a plain compare.
   always_comb begin
      d_in.nz = |c_ff.cp;
      d_in.cp = c_ff.cp[NUM_BITS-1] ? -c_ff.cp : c_ff.cp;
      d_in.sn = c_ff.cp[NUM_BITS-1] ? -c_ff.sn : c_ff.sn;
      d_in.tn = c_ff.cp[NUM_BITS-1] ? -c_ff.tn : c_ff.tn;
      d_in.nx = c_ff.dx[DIFF_BITS-1];
      d_in.ny = c_ff.dy[DIFF_BITS-1];
      d_in.mx = c_ff.dx[DIFF_BITS-1] ? DIFF_BITS'(-c_ff.dx) : DIFF_BITS'(c_ff.dx);
      d_in.my = c_ff.dy[DIFF_BITS-1] ? DIFF_BITS'(-c_ff.dy) : DIFF_BITS'(c_ff.dy);
      d_in.px = c_ff.px;
      d_in.py = c_ff.py;
   end

   always_comb begin
      e_in.hit = d_ff.nz && !d_ff.sn[NUM_BITS-1] && (d_ff.sn <= d_ff.cp)
                 && !d_ff.tn[NUM_BITS-1] && (d_ff.tn <= d_ff.cp);
      e_in.tn    = d_ff.tn[PROD_BITS-1:0];
      e_in.cp    = d_ff.cp[PROD_BITS-1:0];
      e_in.x.r   = '0;
      e_in.x.q   = '0;
      e_in.x.m   = d_ff.mx;
      e_in.x.neg = d_ff.nx;
      e_in.x.p   = d_ff.px;
      e_in.y.r   = '0;
      e_in.y.q   = '0;
      e_in.y.m   = d_ff.my;
      e_in.y.neg = d_ff.ny;
      e_in.y.p   = d_ff.py;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= req_valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_d) vd_ff <= vc_ff;
         if (rdy_e) ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) a_ff <= a_in;
      if (rdy_b) b_ff <= b_in;
      if (rdy_c) c_ff <= c_in;
      if (rdy_d) d_ff <= d_in;
      if (rdy_e) e_ff <= e_in;
   end

endmodule

### src/lsi_cell.sv
// ----------------------------------------------------------------------------
// lsi_cell
// One step of the scaled division: fold in one bit of |d| on each axis.
// ----------------------------------------------------------------------------
module lsi_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lsi_pkg::lsi_cell_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lsi_pkg::lsi_cell_type out_data
);
   import lsi_pkg::*;

   lsi_cell_type data_ff, data_in;
   logic         valid_ff;

   // r' = 2r + bit*tn stays below 3cp, so the quotient digit is 0, 1 or 2.
   function automatic lsi_lane_type lane_step(lsi_lane_type l,
                                              logic [PROD_BITS-1:0] tn,
                                              logic [PROD_BITS-1:0] cp);
      logic [REM_BITS-1:0] sum;
      logic [REM_BITS-1:0] twice;
      logic [REM_BITS-1:0] rem;
      logic [1:0]          digit;
      lsi_lane_type        o;
      sum   = {l.r, 1'b0} + (l.m[DIFF_BITS-1] ? {1'b0, tn} : '0);
      twice = {cp, 1'b0};
      if (sum >= twice) begin
         rem   = sum - twice;
         digit = 2'd2;
      end else if (sum >= {1'b0, cp}) begin
         rem   = sum - {1'b0, cp};
         digit = 2'd1;
      end else begin
         rem   = sum;
         digit = 2'd0;
      end
      o     = l;
      o.r   = rem[PROD_BITS-1:0];
      o.q   = {l.q[DIFF_BITS-2:0], 1'b0} + DIFF_BITS'(digit);
      o.m   = {l.m[DIFF_BITS-2:0], 1'b0};
      return o;
   endfunction

   always_comb begin
      data_in   = in_data;
      data_in.x = lane_step(in_data.x, in_data.tn, in_data.cp);
      data_in.y = lane_step(in_data.y, in_data.tn, in_data.cp);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= data_in;
   end

endmodule

### src/lsi_back.sv
// ----------------------------------------------------------------------------
// lsi_back
// Apply the quotient sign, offset from the probe start, hold the result beat.
// ----------------------------------------------------------------------------
module lsi_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lsi_pkg::lsi_cell_type in_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lsi_pkg::lsi_rsp_type  rsp_data
);
   import lsi_pkg::*;

   lsi_rsp_type rsp_ff, rsp_in;
   logic        valid_ff;

   function automatic logic [COORD_BITS-1:0] place(lsi_lane_type l);
      logic [COORD_BITS-1:0] q;
      q = l.q[COORD_BITS-1:0];
      return l.neg ? (l.p - q) : (l.p + q);
   endfunction

   always_comb begin
      rsp_in.hit   = in_data.hit;
      rsp_in.hit_x = in_data.hit ? place(in_data.x) : '0;
      rsp_in.hit_y = in_data.hit ? place(in_data.y) : '0;
   end

   assign in_ready  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) rsp_ff <= rsp_in;
   end

endmodule

### src/line_segment_intersection.sv
// ----------------------------------------------------------------------------
// line_segment_intersection
// Exact segment-versus-segment hit test with intersection point.
//
// Request beat (req_valid/req_ready/req_data): wall start and end, probe
// segment start and end, signed Q16.16. Response beat (rsp_valid/rsp_ready/
// rsp_data): hit flag and hit point, point zero when there is no hit.
// One response per request, in request order.
// Depth: 39 registers from request accept to rsp_valid (5 front stages,
// 33 division cells, one bit of |d| per cell, 1 output register).
// Throughput: one beat per cycle while rsp_ready stays high; every stage
// holds its own valid bit, and the 33-cell division chain sets the depth.
// When the receiver stalls, the response holds in the output register while
// empty stages upstream keep filling; req_ready drops only once the whole
// pipe is full. Reset empties every stage; no request is pending after it.
// ----------------------------------------------------------------------------
module line_segment_intersection (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lsi_pkg::lsi_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lsi_pkg::lsi_rsp_type rsp_data
);
   import lsi_pkg::*;

   // chain[0] is the front output, chain[DIFF_BITS] feeds the output stage
   logic         chain_valid [DIFF_BITS+1];
   logic         chain_ready [DIFF_BITS+1];
   lsi_cell_type chain_data  [DIFF_BITS+1];

   lsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // One cell per bit of |d|, most significant first.
   for (genvar k = 0; k < DIFF_BITS; k++) begin : g_cell
      lsi_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   lsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[DIFF_BITS]),
      .in_ready  (chain_ready[DIFF_BITS]),
      .in_data   (chain_data[DIFF_BITS]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment intersection pipeline.
//
// Each request beat gets its expected response from an exact wide-integer
// predictor. A checker process compares every response beat, field by
// field, against the oldest prediction. Test tasks run in turn: special
// cases, random segment pairs under three idling profiles, and a long
// receiver hold-off that fills the pipe.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lsi_pkg::*;

   localparam int LATENCY   = 39;
   localparam int WDOG_MAX  = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   lsi_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   lsi_rsp_type rsp_data;

   line_segment_intersection i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   lsi_rsp_type pending_hits[$];
   int          errors = 0;
   int          send_idle_pct = 0;   // sender gap chance, percent
   int          recv_idle_pct = 0;   // receiver stall chance, percent
   bit          hold_off = 1'b0;     // receiver held low for a stretch
   int          idle_cycles = 0;

   // Exact intersection predictor. 160-bit signed math never overflows:
   // differences fit 33 bits, products 66, tn*d about 100.
   typedef logic signed [159:0] wide_t;

   function automatic lsi_rsp_type predict_hit(lsi_req_type r);
      lsi_rsp_type o;
      wide_t dx, dy, lx, ly, ax, ay, cp, sn, tn, qx, qy;
      o = '0;
      dx = wide_t'(r.ray_to_x) - wide_t'(r.ray_from_x);
      dy = wide_t'(r.ray_to_y) - wide_t'(r.ray_from_y);
      lx = wide_t'(r.wall_end_x) - wide_t'(r.wall_start_x);
      ly = wide_t'(r.wall_end_y) - wide_t'(r.wall_start_y);
      ax = wide_t'(r.ray_from_x) - wide_t'(r.wall_start_x);
      ay = wide_t'(r.ray_from_y) - wide_t'(r.wall_start_y);
      cp = dx * ly - lx * dy;
      if (cp == 0) return o;
      sn = dx * ay - dy * ax;
      tn = lx * ay - ly * ax;
      if (cp < 0) begin
         cp = -cp;
         sn = -sn;
         tn = -tn;
      end
      if (sn >= 0 && sn <= cp && tn >= 0 && tn <= cp) begin
         // SystemVerilog signed division truncates toward zero
         qx = (tn * dx) / cp;
         qy = (tn * dy) / cp;
         o.hit   = 1'b1;
         o.hit_x = COORD_BITS'(wide_t'(r.ray_from_x) + qx);
         o.hit_y = COORD_BITS'(wide_t'(r.ray_from_y) + qy);
      end
      return o;
   endfunction

   // Drive one request beat; hold it until accepted. Drop valid only while
   // idling, so back-to-back beats keep it high.
   task automatic send_segments(lsi_req_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_hits.push_back(predict_hit(r));
   endtask

   // Receiver readiness, redrawn every edge.
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
   end

   // Compare each response beat against the oldest prediction.
   always @(posedge clock) begin
      lsi_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $display("%0t: hit exp %b got %b", $time, want.hit, rsp_data.hit);
               errors++;
            end
            if (rsp_data.hit_x !== want.hit_x) begin
               $display("%0t: hit_x exp %h got %h", $time, want.hit_x, rsp_data.hit_x);
               errors++;
            end
            if (rsp_data.hit_y !== want.hit_y) begin
               $display("%0t: hit_y exp %h got %h", $time, want.hit_y, rsp_data.hit_y);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;  // near origin
         default: return $urandom();
      endcase
   endfunction

   function automatic lsi_req_type mk_req(int sx, int sy, int ex, int ey,
                                          int px, int py, int qx, int qy);
      lsi_req_type r;
      r.wall_start_x = sx; r.wall_start_y = sy;
      r.wall_end_x   = ex; r.wall_end_y   = ey;
      r.ray_from_x   = px; r.ray_from_y   = py;
      r.ray_to_x     = qx; r.ray_to_y     = qy;
      return r;
   endfunction

   // Random pair; mostly crossing a shared point so hits are common.
   function automatic lsi_req_type random_pair();
      lsi_req_type r;
      logic [31:0] cx, cy;
      int m;
      m = $urandom_range(9);
      if (m < 4) begin
         r = {pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), pick_coord()};
      end else begin
         // segments through a common point, spreads kept inside the range
         cx = $urandom() >> 1;
         cy = $urandom() >> 1;
         cx = cx - 32'h4000_0000;
         cy = cy - 32'h4000_0000;
         r.wall_start_x = cx - ($urandom() >> 3);
         r.wall_start_y = cy - ($urandom() >> 3);
         r.wall_end_x   = cx + ($urandom() >> 3);
         r.wall_end_y   = cy + ($urandom() >> 3);
         r.ray_from_x   = cx + ($urandom() >> 3);
         r.ray_from_y   = cy - ($urandom() >> 3);
         r.ray_to_x     = cx - ($urandom() >> 3);
         r.ray_to_y     = cy + ($urandom() >> 3);
         if (m == 9) r.ray_to_x = r.ray_from_x;   // occasionally axis-aligned
      end
      return r;
   endfunction

   task automatic test_special_cases();
      localparam int ONE = 32'h0001_0000;
      int mn, mx;
      mn = 32'h8000_0000;
      mx = 32'h7fff_ffff;
      send_segments(mk_req(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0));   // plain cross
      send_segments(mk_req(0, 0, ONE, 0, 0, ONE, ONE, ONE));           // parallel
      send_segments(mk_req(0, 0, ONE, 0, 2*ONE, 0, 3*ONE, 0));         // collinear
      send_segments(mk_req(0, 0, ONE, ONE, 0, ONE, ONE, 0));           // crossing mid
      send_segments(mk_req(0, 0, ONE, 0, 0, 0, 0, ONE));               // touch at start
      send_segments(mk_req(0, 0, ONE, 0, ONE, -ONE, ONE, 0));          // touch at end
      send_segments(mk_req(0, 0, ONE, 0, 2*ONE, -ONE, 2*ONE, ONE));    // miss beyond
      send_segments(mk_req(ONE, ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE));   // point wall
      send_segments(mk_req(0, 0, ONE, ONE, 5, 5, 5, 5));               // point probe
      send_segments(mk_req(mn, mn, mx, mx, mn, mx, mx, mn));           // full range X
      send_segments(mk_req(mn, 0, mx, 0, 0, mn, 0, mx));               // full axes
      send_segments(mk_req(mx, mn, mn, mx, mx, mx, mn, mn));
      send_segments(mk_req(mn, mn, mn, mn, mn, mn, mn, mn));
      send_segments(mk_req(mx, mx, mx, mx, mx, mx, mx, mx));
      send_segments(mk_req(-1, -1, 1, 1, -1, 1, 1, -1));               // truncation
      send_segments(mk_req(0, 0, 3, 1, 0, 1, 7, -2));
      send_segments(mk_req(-3, 0, 4, 1, 2, -5, -1, 6));
      send_segments(mk_req(mn, mx, mx, mn, 0, 0, mx, mx));
   endtask

   task automatic test_random(int count, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) send_segments(random_pair());
   endtask

   // Hold the receiver off so the pipe fills and req_ready drops.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (80) send_segments(random_pair());
      join
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_random(160, 15, 58);
      test_random(160, 58, 15);
      test_random(160, 0, 0);
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
